FILE: sv/tdi_pkg.sv
// Shared types and constants for the tile deduplicating indexer.
// Used by every module of the block but tdi_ram; no dependencies of its own.
package tdi_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int CAP_LIMIT     = 256;
    localparam int CAP           = (TABLE_ENTRIES < CAP_LIMIT) ? TABLE_ENTRIES : CAP_LIMIT;
    localparam int ADDR_W        = $clog2(CAP);
    localparam int STD_COUNT     = 4;
    localparam int STD_LIMIT     = (CAP > STD_COUNT) ? CAP - STD_COUNT : 0;
    localparam int QUEUE_DEPTH   = 2;

    localparam int PLANE_W  = 64;
    localparam int TILE_W   = 2 * PLANE_W;
    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 8;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 24;

    localparam logic [CNT_W-1:0] CAP_CNT       = CNT_W'(CAP);
    localparam logic [CNT_W-1:0] STD_LIMIT_CNT = CNT_W'(STD_LIMIT);
    localparam logic [IDX_W-1:0] STD_BASE      = 8'hFC;
    localparam logic [IDX_W-1:0] OVF_INDEX     = 8'h00;

    // Fixed tiles, entry 0 first: color 3, plane0 only, plane1 only, blank
    localparam logic [STD_COUNT-1:0][PLANE_W-1:0] STD_P0 = {
        64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF
    };
    localparam logic [STD_COUNT-1:0][PLANE_W-1:0] STD_P1 = {
        64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_INDEX = 2'd0,
        CFG_STD_ENABLE  = 2'd1,
        CFG_FLAT_MODE   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic             std_en;
        logic             flat;
    } cfg_t;

    typedef struct packed {
        logic [PLANE_W-1:0] plane1;
        logic [PLANE_W-1:0] plane0;
        logic               first;
        logic               std_hit;
        logic [1:0]         std_code;
    } tile_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] unique_count;
        logic             overflow;
        logic             is_standard;
        logic             is_new;
        logic [IDX_W-1:0] tile_index;
    } result_t;

endpackage

FILE: sv/tdi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdi_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: sv/tdi_front.sv
// Front end: takes input transfers and classifies each tile against the fixed tiles.
// Depends on tdi_pkg.
module tdi_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tdi_pkg::S_DATA_W-1:0]  s_tdata,   // plane0_rows, plane1_rows
    input  logic                          s_tuser,   // first_of_image
    input  tdi_pkg::cfg_t                 cfg,
    input  logic                          q_full,
    output logic                          q_push,
    output tdi_pkg::tile_item_t           q_item
);
    import tdi_pkg::*;

    logic [PLANE_W-1:0] p0;
    logic [PLANE_W-1:0] p1;
    logic               any_hit;
    logic [1:0]         hit_code;

    assign p0 = s_tdata[PLANE_W-1:0];
    assign p1 = s_tdata[TILE_W-1:PLANE_W];

    // Walk down so the lowest matching fixed tile wins
    always_comb begin
        any_hit  = 1'b0;
        hit_code = '0;
        for (int c = STD_COUNT - 1; c >= 0; c--) begin
            if (p0 == STD_P0[c] && p1 == STD_P1[c]) begin
                any_hit  = 1'b1;
                hit_code = 2'(c);
            end
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.plane0   = p0;
        q_item.plane1   = p1;
        q_item.first    = s_tuser;
        q_item.std_hit  = any_hit && cfg.std_en && !cfg.flat;
        q_item.std_code = hit_code;
    end
endmodule

FILE: sv/tdi_queue.sv
// Short queue of classified tiles between the front end and the search engine.
// Depends on tdi_pkg.
module tdi_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tdi_pkg::tile_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output tdi_pkg::tile_item_t head_item
);
    import tdi_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

    tile_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = CNT_QW'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_QW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

FILE: sv/tdi_back.sv
// Search engine: scans the stored tiles, appends new ones and drives the result register.
// Depends on tdi_pkg and tdi_ram.
module tdi_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tdi_pkg::cfg_t                cfg,
    input  logic                         q_valid,
    input  tdi_pkg::tile_item_t          q_item,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tdi_pkg::M_DATA_W-1:0] m_tdata
);
    import tdi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_APPEND = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    tile_item_t         item_reg, item_next;
    logic [CNT_W-1:0]   nf_reg, nf_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [ADDR_W-1:0]  cmp_addr_reg, cmp_addr_next;
    logic               cmp_valid_reg, cmp_valid_next;
    result_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;

    logic [CNT_W-1:0]   nf_start;
    logic [CNT_W-1:0]   nf_limit;
    logic               out_free;
    logic               wr_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [TILE_W-1:0]  rd_data;

    tdi_ram #(
        .WIDTH (TILE_W),
        .DEPTH (CAP)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (nf_reg[ADDR_W-1:0]),
        .wr_data ({item_reg.plane1, item_reg.plane0}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next free slot as seen by the item at the queue head
    always_comb begin
        nf_start = q_item.first ? CNT_W'(cfg.first_index) : nf_reg;
        if (nf_start > CAP_CNT) begin
            nf_start = CAP_CNT;
        end
    end

    always_comb begin
        if (cfg.flat || !cfg.std_en) begin
            nf_limit = CAP_CNT;
        end else begin
            nf_limit = STD_LIMIT_CNT;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        nf_next        = nf_reg;
        scan_next      = scan_reg;
        cmp_addr_next  = cmp_addr_reg;
        cmp_valid_next = 1'b0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = scan_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    nf_next   = nf_start;
                    scan_next = CNT_W'(cfg.first_index);
                    if (cfg.flat) begin
                        state_next = ST_APPEND;
                    end else if (q_item.std_hit) begin
                        res_next.tile_index   = STD_BASE | IDX_W'(q_item.std_code);
                        res_next.is_new       = 1'b0;
                        res_next.is_standard  = 1'b1;
                        res_next.overflow     = 1'b0;
                        res_next.unique_count = nf_start;
                        state_next            = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Compare the entry read last cycle while issuing the next read
                if (cmp_valid_reg && rd_data == {item_reg.plane1, item_reg.plane0}) begin
                    res_next.tile_index   = IDX_W'(cmp_addr_reg);
                    res_next.is_new       = 1'b0;
                    res_next.is_standard  = 1'b0;
                    res_next.overflow     = 1'b0;
                    res_next.unique_count = nf_reg;
                    state_next            = ST_RESULT;
                end else if (scan_reg < nf_reg) begin
                    cmp_addr_next  = scan_reg[ADDR_W-1:0];
                    cmp_valid_next = 1'b1;
                    scan_next      = CNT_W'(scan_reg + 1'b1);
                end else begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (nf_reg >= nf_limit) begin
                    res_next.tile_index   = OVF_INDEX;
                    res_next.is_new       = 1'b0;
                    res_next.is_standard  = 1'b0;
                    res_next.overflow     = 1'b1;
                    res_next.unique_count = nf_reg;
                end else begin
                    wr_en                 = 1'b1;
                    nf_next               = CNT_W'(nf_reg + 1'b1);
                    res_next.tile_index   = nf_reg[IDX_W-1:0];
                    res_next.is_new       = 1'b1;
                    res_next.is_standard  = 1'b0;
                    res_next.overflow     = 1'b0;
                    res_next.unique_count = CNT_W'(nf_reg + 1'b1);
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // Hold until the output register frees up
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            nf_reg        <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            nf_reg        <= nf_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        scan_reg     <= scan_next;
        cmp_addr_reg <= cmp_addr_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_data_reg);

`ifndef SYNTHESIS
    a_nf_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nf_reg <= CAP_CNT)
        else $error("next free slot beyond table capacity");

    a_append_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> nf_reg == CNT_W'($past(nf_reg) + 1'b1))
        else $error("append did not advance next free slot");

    a_write_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (nf_reg < nf_limit && state_reg == ST_APPEND))
        else $error("store written outside an allowed append");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> $onehot0({out_data_reg.is_new, out_data_reg.is_standard,
                                    out_data_reg.overflow}))
        else $error("result carries conflicting flags");
`endif
endmodule

FILE: sv/tile_dedup_indexer_unit.sv
// Tile deduplicating indexer: returns the tile table index of each 8x8 two-plane tile.
// The search engine reads stored entries from first_index up to the next free slot,
// one 128-bit entry of the tile store per cycle, up to all 256 entries; a fixed-tile
// match and a flat-mode append skip the scan. A two-entry queue takes new tiles while
// a search runs and a result waits on the output register. The tile store needs no
// clearing after reset if the user sees that entries are read only once written, and
// the user writes configuration through the cfg port only while idle; the block itself
// enforces neither. Depends on tdi_pkg, tdi_front, tdi_queue, tdi_back and tdi_ram.
module tile_dedup_indexer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tdi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdi_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tdi_pkg::S_DATA_W-1:0]   s_tdata,  // plane0_rows, plane1_rows
    input  logic                           s_tuser,  // first_of_image
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tile_index, is_new, is_standard, overflow, unique_count, zero pad
    output logic [tdi_pkg::M_DATA_W-1:0]   m_tdata
);
    import tdi_pkg::*;

    cfg_t       cfg_reg;
    logic       q_full;
    logic       q_push;
    tile_item_t q_push_item;
    logic       q_pop;
    logic       q_valid;
    tile_item_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FIRST_INDEX: cfg_reg.first_index <= cfg_wdata;
                CFG_STD_ENABLE:  cfg_reg.std_en      <= cfg_wdata[0];
                CFG_FLAT_MODE:   cfg_reg.flat        <= cfg_wdata[0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    tdi_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_push_item)
    );

    tdi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    tdi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

FILE: test/tile_dedup_indexer_unit_tb.sv
// Self-checking testbench for tile_dedup_indexer_unit: drives tiles over the input stream,
// predicts each table index in a scoreboard class and compares every result field.
// Depends on tdi_pkg and the tile_dedup_indexer_unit RTL.
`timescale 1ns / 100ps

module tile_dedup_indexer_unit_tb;
    import tdi_pkg::*;

    localparam int RANDOM_TILES = 610;
    localparam int TAIL_CYCLES  = 300;
    localparam int MAX_REPORTS  = 50;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    cfg_idx_t             cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // plane0_rows, plane1_rows
    logic                 s_tuser;   // first_of_image
    logic                 m_tvalid;
    logic                 m_tready;
    // tile_index, is_new, is_standard, overflow, unique_count, zero pad
    logic [M_DATA_W-1:0]  m_tdata;

    class tile_index_scoreboard;
        logic [TILE_W-1:0] tile_table [CAP];
        bit                written    [CAP];
        bit [CNT_W-1:0]    next_free;
        bit [IDX_W-1:0]    first_index;
        bit                std_en;
        bit                flat;
        result_t           expected_q [$];
        int                errors;

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_FIRST_INDEX: first_index = val;
                CFG_STD_ENABLE:  std_en = val[0];
                CFG_FLAT_MODE:   flat = val[0];
                default: ;
            endcase
        endfunction

        // True when the search for this tile touches only entries already written
        function bit search_is_safe(bit first);
            int top;
            top = first ? first_index : next_free;
            for (int c = first_index; c < top; c++) begin
                if (!written[c])
                    return 0;
            end
            return 1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_tile(logic [PLANE_W-1:0] p0, logic [PLANE_W-1:0] p1, bit first);
            result_t r;
            int      limit;
            bit      hit;
            r     = '0;
            hit   = 0;
            limit = CAP;
            if (first)
                next_free = CNT_W'(first_index);
            if (!flat) begin
                if (std_en) begin
                    for (int c = 0; c < STD_COUNT && !hit; c++) begin
                        if (STD_P0[c] == p0 && STD_P1[c] == p1) begin
                            r.tile_index  = STD_BASE + IDX_W'(c);
                            r.is_standard = 1'b1;
                            hit = 1;
                        end
                    end
                    limit = STD_LIMIT;
                end
                // lowest stored index of this image wins
                for (int c = first_index; c < next_free && !hit; c++) begin
                    if (tile_table[c] == {p1, p0}) begin
                        r.tile_index = IDX_W'(c);
                        hit = 1;
                    end
                end
            end
            if (!hit) begin
                if (next_free >= limit) begin
                    r.tile_index = OVF_INDEX;
                    r.overflow   = 1'b1;
                end else begin
                    tile_table[next_free] = {p1, p0};
                    written[next_free]    = 1;
                    r.tile_index = next_free[IDX_W-1:0];
                    r.is_new     = 1'b1;
                    next_free++;
                end
            end
            r.unique_count = next_free;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("[%0t] %s", $time, msg);
            errors++;
        endtask

        task cmp_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
            if (got !== want)
                report($sformatf("%s: got %h, want %h", name, got, want));
        endtask

        task check_result(logic [M_DATA_W-1:0] d);
            result_t got;
            result_t want;
            got = result_t'(d[$bits(result_t)-1:0]);
            if (expected_q.size() == 0) begin
                report($sformatf("result %h with no tile outstanding", d));
                return;
            end
            want = expected_q.pop_front();
            cmp_field("tile_index", CNT_W'(got.tile_index), CNT_W'(want.tile_index));
            cmp_field("is_new", CNT_W'(got.is_new), CNT_W'(want.is_new));
            cmp_field("is_standard", CNT_W'(got.is_standard), CNT_W'(want.is_standard));
            cmp_field("overflow", CNT_W'(got.overflow), CNT_W'(want.overflow));
            cmp_field("unique_count", got.unique_count, want.unique_count);
        endtask
    endclass

    tile_index_scoreboard sb = new();
    logic [TILE_W-1:0]    palette [$];
    bit                   calm;
    int                   tiles_sent;

    tile_dedup_indexer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [TILE_W-1:0] std_tile(int c);
        return {STD_P1[c], STD_P0[c]};
    endfunction

    function automatic logic [TILE_W-1:0] rand_tile();
        logic [TILE_W-1:0] t;
        int r;
        t = {$urandom, $urandom, $urandom, $urandom};
        r = $urandom_range(0, 9);
        if (r == 0)
            t = TILE_W'(1) << $urandom_range(0, TILE_W-1);
        else if (r == 1)   // one pixel bit away from a fixed tile
            t = std_tile($urandom_range(0, STD_COUNT-1)) ^ (TILE_W'(1) << $urandom_range(0, TILE_W-1));
        else if (r == 2)
            t[PLANE_W-1:0] = t[TILE_W-1:PLANE_W];
        return t;
    endfunction

    function automatic logic [TILE_W-1:0] image_tile();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65 && palette.size() > 0)
            return palette[$urandom_range(0, palette.size()-1)];
        if (r < 75)
            return std_tile($urandom_range(0, STD_COUNT-1));
        return rand_tile();
    endfunction

    task automatic send_tile(input logic [TILE_W-1:0] tile, input bit first);
        int gap;
        gap = pick_gap();
        // never let a search reach an entry that was never written
        if (!sb.search_is_safe(first))
            first = 1'b1;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tile;
        s_tuser  <= first;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_tile(tile[PLANE_W-1:0], tile[TILE_W-1:PLANE_W], first);
        tiles_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] first_idx, input logic std_on,
                              input logic flat_on);
        cfg_idx_t         regs [3];
        logic [CFG_W-1:0] vals [3];
        regs = '{CFG_FIRST_INDEX, CFG_STD_ENABLE, CFG_FLAT_MODE};
        vals = '{first_idx, CFG_W'(std_on), CFG_W'(flat_on)};
        drain();
        cfg_wr_en <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(regs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_image(int len, int pal_size, bit restart);
        bit first;
        palette.delete();
        repeat (pal_size) palette.push_back(rand_tile());
        for (int i = 0; i < len; i++) begin
            first = (i == 0) ? restart : ($urandom_range(0, 49) == 0);
            send_tile(image_tile(), first);
            if ($urandom_range(0, 99) == 0)
                drain();
        end
    endtask

    // Result side: random stalls, sometimes long stretches of steady ready
    initial begin
        int run;
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            run = calm ? 50 : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_result(m_tdata);
    end

    initial begin
        logic [TILE_W-1:0] t0;
        int                fi;
        int                phase;
        int                target;
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_FIRST_INDEX;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        calm       = 1'b0;
        tiles_sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // No image start yet: appends begin at index zero, blank is an ordinary tile
        send_tile('0, 1'b0);
        send_tile('1, 1'b0);
        send_tile('0, 1'b0);
        send_tile(std_tile(1), 1'b0);

        // Fixed tiles on, table top reserved: two appends, then overflow
        write_regs(8'd250, 1'b1, 1'b0);
        t0 = rand_tile();
        send_tile(t0, 1'b1);
        send_tile(rand_tile(), 1'b0);
        send_tile(rand_tile(), 1'b0);
        for (int c = 0; c < STD_COUNT; c++)
            send_tile(std_tile(c), 1'b0);
        send_tile(t0, 1'b0);
        send_tile(std_tile(0), 1'b1);

        // Flat mode ignores fixed tiles and fills up to the last index
        write_regs(8'd255, 1'b1, 1'b1);
        send_tile(std_tile(3), 1'b1);
        send_tile(std_tile(3), 1'b0);
        send_tile('1, 1'b0);
        send_tile(rand_tile(), 1'b1);

        // Lowering first_index within an image would reach unwritten entries: restart
        write_regs(8'd0, 1'b0, 1'b0);
        send_tile(rand_tile(), 1'b1);
        send_tile(t0, 1'b0);

        phase  = 0;
        target = tiles_sent + RANDOM_TILES;
        while (tiles_sent < target) begin
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // fill the whole table, then overflow and full-length searches
                write_regs(8'd0, 1'b0, 1'b0);
                palette.delete();
                repeat (CAP + 4) palette.push_back(rand_tile());
                foreach (palette[i])
                    send_tile(palette[i], i == 0);
                repeat (16) send_tile(palette[$urandom_range(0, palette.size()-1)], 1'b0);
            end else begin
                case ($urandom_range(0, 5))
                    0: fi = 0;
                    1: fi = 255;
                    2: fi = STD_BASE;
                    3: fi = $urandom_range(200, 255);
                    default: fi = $urandom_range(0, 255);
                endcase
                write_regs(CFG_W'(fi), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
                // the first image sometimes carries on across the register change
                repeat ($urandom_range(1, 4))
                    run_image($urandom_range(5, 40), $urandom_range(1, 12),
                              $urandom_range(0, 3) != 0);
            end
            phase++;
        end

        calm = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
